// ----- sv/hstq_pkg.sv -----
// Shared constants and codes for the hashed string table.
`default_nettype none
package hstq_pkg;
   localparam int KEY_W   = 120;   // 15 key bytes
   localparam int LEN_W   = 4;
   localparam int ENTRY_W = KEY_W + LEN_W;
   localparam int SUM_W   = 15;    // 255 * (1 + 2 + ... + 15) fits
   localparam int PROD_W  = 20;    // 19 * sum fits
   localparam int HASH_MULT  = 19;
   localparam int PROBE_LIN  = 23;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 144;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_PRESENT  = 3'd1;
   localparam logic [2:0] ST_NO_FREE  = 3'd2;
   localparam logic [2:0] ST_DELETED  = 3'd3;
   localparam logic [2:0] ST_NOT_FND  = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;
   localparam logic [2:0] ST_READ     = 3'd6;
   localparam logic [2:0] ST_CLEARED  = 3'd7;
endpackage
`default_nettype wire

// ----- sv/hashed_string_table_quadratic_probe.sv -----
// Top level: string key table in one slot memory, searched and probed by a sequencer.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser command, tdata key, length, slot
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser status, tdata slot, count, key
//  (no configuration port)
//
// Insert/delete scan every slot, one memory read a cycle.
// Insert of a new key adds the byte-serial hash and up to PROBE_LIMIT probes.
// Read passes S_READ and S_READQ to S_EMIT; clear and empty-key go straight to S_EMIT,
// which loads the result; the longest item is a new 15-byte key.
// Slot valid bits are flip-flops cleared by reset and by the clear command.
// A new beat is taken while the previous result still waits on rsp_tready.
`default_nettype none
module hashed_string_table_quadratic_probe #(
   parameter int TABLE_SLOTS   = 101,
   parameter int PROBE_LIMIT   = 20,
   parameter int MAX_KEY_CHARS = 15
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // lsb up: key_chars_lo[64], key_chars_hi[56], key_length[4], slot_index[7], zero pad[5]
   input  wire logic [hstq_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[2]
   input  wire logic [1:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // lsb up: slot[7], entry_count[7], slot_occupied[1], slot_key_lo[64],
   // slot_key_hi[56], slot_key_length[4], zero pad[5]
   output logic [hstq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status[3]
   output logic [2:0]                           rsp_tuser
);
   import hstq_pkg::*;

   localparam int SLOT_W  = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
   localparam int PROBE_W = $clog2(PROBE_LIMIT + 1);
   localparam int STEP0   = (1 + PROBE_LIN) % TABLE_SLOTS;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_PROBE  = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_READQ  = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   logic [ENTRY_W-1:0] mem [TABLE_SLOTS];
   logic [ENTRY_W-1:0] mem_q_ff;

   logic [2:0]             state_ff, state_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [6:0]             idx_ff, idx_in;
   logic [TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SLOT_W:0]        scan_ff, scan_in;
   logic                   q_vld_ff, q_vld_in;
   logic [SLOT_W-1:0]      q_addr_ff, q_addr_in;
   logic                   found_ff, found_in;
   logic [SLOT_W-1:0]      found_idx_ff, found_idx_in;
   logic [SLOT_W-1:0]      p_ff, p_in;
   logic [SLOT_W-1:0]      step_ff, step_in;
   logic [PROBE_W-1:0]     j_ff, j_in;
   logic [2:0]             res_status_ff, res_status_in;
   logic [6:0]             res_slot_ff, res_slot_in;
   logic                   res_occ_ff, res_occ_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [2:0]             rsp_user_ff, rsp_user_in;

   logic [KEY_W-1:0]  req_key;
   logic [LEN_W-1:0]  req_len;
   logic [6:0]        req_idx;
   logic [LEN_W-1:0]  len_sat;
   logic [KEY_W-1:0]  key_trim;
   logic              accept;
   logic              mem_ren;
   logic [SLOT_W-1:0] mem_raddr;
   logic              mem_we;
   logic              match;
   logic              search_done;
   logic              idx_in_range;
   logic              hash_start;
   logic              hash_done;
   logic [SLOT_W-1:0] hash_home;
   logic [SLOT_W:0]   p_sum;
   logic [SLOT_W:0]   step_sum;

   assign req_key = req_tdata[KEY_W-1:0];
   assign req_len = req_tdata[KEY_W +: LEN_W];
   assign req_idx = req_tdata[KEY_W+LEN_W +: 7];
   assign len_sat = (32'(req_len) > MAX_KEY_CHARS) ? LEN_W'(MAX_KEY_CHARS) : req_len;

   always_comb begin
      for (int b = 0; b < KEY_W / 8; b++) begin
         key_trim[b*8 +: 8] = (b < 32'(len_sat)) ? req_key[b*8 +: 8] : 8'd0;
      end
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign idx_in_range = 32'(idx_ff) < TABLE_SLOTS;
   assign search_done  = (32'(scan_ff) == TABLE_SLOTS) && !q_vld_ff;
   assign match        = q_vld_ff && valid_ff[q_addr_ff] && (mem_q_ff == {len_ff, key_ff});
   assign mem_we       = (state_ff == S_PROBE) && !valid_ff[p_ff];
   assign hash_start   = (state_ff == S_SEARCH) && search_done && (cmd_ff == CMD_INSERT)
                         && !found_ff;
   assign p_sum        = {1'b0, p_ff} + {1'b0, step_ff};
   assign step_sum     = {1'b0, step_ff} + (SLOT_W+1)'(2);

   always_comb begin
      mem_ren   = 1'b0;
      mem_raddr = scan_ff[SLOT_W-1:0];
      if (state_ff == S_SEARCH && 32'(scan_ff) < TABLE_SLOTS) begin
         mem_ren = 1'b1;
      end else if (state_ff == S_READ && idx_in_range) begin
         mem_ren   = 1'b1;
         mem_raddr = SLOT_W'(idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[p_ff] <= {len_ff, key_ff};
      end
      if (mem_ren) begin
         mem_q_ff <= mem[mem_raddr];
      end
   end

   hstq_hash #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .SLOT_W      (SLOT_W)
   ) u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key     (key_ff),
      .key_len (len_ff),
      .done    (hash_done),
      .home    (hash_home)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      q_vld_in      = 1'b0;
      q_addr_in     = scan_ff[SLOT_W-1:0];
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      p_in          = p_ff;
      step_in       = step_ff;
      j_in          = j_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_occ_in    = res_occ_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in      = req_tuser;
               key_in      = key_trim;
               len_in      = len_sat;
               idx_in      = req_idx;
               res_occ_in  = 1'b0;
               res_slot_in = '0;
               scan_in     = '0;
               found_in    = 1'b0;
               case (req_tuser)
                  CMD_INSERT, CMD_DELETE: begin
                     if (len_sat == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  CMD_READ: state_in = S_READ;
                  CMD_CLEAR: begin
                     valid_in      = '0;
                     count_in      = '0;
                     res_status_in = ST_CLEARED;
                     state_in      = S_EMIT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SEARCH: begin
            // read issued at scan, compared in the next cycle
            if (32'(scan_ff) < TABLE_SLOTS) begin
               q_vld_in = 1'b1;
               scan_in  = scan_ff + 1'b1;
            end
            if (match && !found_ff) begin
               found_in     = 1'b1;
               found_idx_in = q_addr_ff;
            end
            if (search_done) begin
               if (cmd_ff == CMD_INSERT) begin
                  if (found_ff) begin
                     res_status_in = ST_PRESENT;
                     state_in      = S_EMIT;
                  end else begin
                     state_in = S_HASH;
                  end
               end else if (found_ff) begin
                  valid_in[found_idx_ff] = 1'b0;
                  count_in               = count_ff - 1'b1;
                  res_status_in          = ST_DELETED;
                  res_slot_in            = 7'(found_idx_ff);
                  state_in               = S_EMIT;
               end else begin
                  res_status_in = ST_NOT_FND;
                  state_in      = S_EMIT;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               p_in     = hash_home;
               step_in  = SLOT_W'(STEP0);
               j_in     = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            // offset grows by 2j+24 each probe, kept reduced
            if (!valid_ff[p_ff]) begin
               valid_in[p_ff] = 1'b1;
               count_in       = count_ff + 1'b1;
               res_status_in  = ST_INSERTED;
               res_slot_in    = 7'(p_ff);
               state_in       = S_EMIT;
            end else if (32'(j_ff) == PROBE_LIMIT - 1) begin
               res_status_in = ST_NO_FREE;
               state_in      = S_EMIT;
            end else begin
               j_in    = j_ff + 1'b1;
               p_in    = (32'(p_sum) >= TABLE_SLOTS) ?
                         SLOT_W'(p_sum - (SLOT_W+1)'(TABLE_SLOTS)) : SLOT_W'(p_sum);
               step_in = (32'(step_sum) >= TABLE_SLOTS) ?
                         SLOT_W'(step_sum - (SLOT_W+1)'(TABLE_SLOTS)) : SLOT_W'(step_sum);
            end
         end
         S_READ: begin
            state_in = S_READQ;
         end
         S_READQ: begin
            res_status_in = ST_READ;
            res_slot_in   = idx_ff;
            res_occ_in    = idx_in_range && valid_ff[SLOT_W'(idx_ff)];
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (state_ff == S_EMIT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = res_status_ff;
         rsp_data_in  = RSP_DATA_W'({
            res_occ_ff ? mem_q_ff : {ENTRY_W{1'b0}},
            res_occ_ff,
            7'(count_ff),
            res_slot_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         q_vld_ff     <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         q_vld_ff     <= q_vld_in;
         found_ff     <= found_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      scan_ff       <= scan_in;
      q_addr_ff     <= q_addr_in;
      found_idx_ff  <= found_idx_in;
      p_ff          <= p_in;
      step_ff       <= step_in;
      j_ff          <= j_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_occ_ff    <= res_occ_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule
`default_nettype wire

// ----- sv/hstq_hash.sv -----
// Byte-serial home slot computation: weighted byte sum, times 19, reciprocal-multiply remainder.
`default_nettype none
module hstq_hash #(
   parameter int TABLE_SLOTS = 101,
   parameter int SLOT_W      = 7
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [hstq_pkg::KEY_W-1:0] key,
   input  wire logic [hstq_pkg::LEN_W-1:0] key_len,
   output logic                            done,
   output logic [SLOT_W-1:0]               home
);
   import hstq_pkg::*;

   localparam logic [2:0] H_IDLE = 3'd0;
   localparam logic [2:0] H_SUM  = 3'd1;
   localparam logic [2:0] H_MUL  = 3'd2;
   localparam logic [2:0] H_QUO  = 3'd3;
   localparam logic [2:0] H_REM  = 3'd4;

   // floor(2^32 / slots) + 1: exact quotient for any product below 2^PROD_W
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_SLOTS) + 64'd1);

   logic [2:0]         state_ff, state_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]  quo_ff, quo_in;
   logic [SLOT_W-1:0]  rem_ff, rem_in;
   logic               done_ff, done_in;
   logic [7:0]         cur_byte;
   logic [11:0]        term;
   logic [PROD_W+31:0] quo_full;
   logic [PROD_W-1:0]  rem_full;

   assign cur_byte = key[{idx_ff, 3'b000} +: 8];
   assign term     = 12'(cur_byte) * 12'({1'b0, idx_ff} + 5'd1);
   assign quo_full = {32'd0, prod_ff} * {PROD_W'(0), RECIP};
   assign rem_full = prod_ff - quo_ff * PROD_W'(TABLE_SLOTS);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               idx_in   = '0;
               sum_in   = '0;
               state_in = H_SUM;
            end
         end
         H_SUM: begin
            sum_in = sum_ff + SUM_W'(term);
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == key_len) begin
               state_in = H_MUL;
            end
         end
         H_MUL: begin
            prod_in  = PROD_W'(sum_ff) * PROD_W'(HASH_MULT);
            state_in = H_QUO;
         end
         H_QUO: begin
            quo_in   = quo_full[PROD_W+31:32];
            state_in = H_REM;
         end
         H_REM: begin
            rem_in   = rem_full[SLOT_W-1:0];
            done_in  = 1'b1;
            state_in = H_IDLE;
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;
endmodule
`default_nettype wire

// ----- sim/tb_hashed_string_table_quadratic_probe.sv -----
// Self-checking bench for the quadratic-probe string key table.
`timescale 1ns / 100ps
`default_nettype none
module tb_hashed_string_table_quadratic_probe;
   import hstq_pkg::*;

   localparam int SLOTS = 101;
   localparam int PROBES = 20;
   localparam int MAXC = 15;
   localparam longint LIMIT = 3000000;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  slot;
      logic [6:0]  count;
      logic        occ;
      logic [63:0] klo;
      logic [55:0] khi;
      logic [3:0]  klen;
   } table_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0] rsp_tuser;

   hashed_string_table_quadratic_probe u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // shadow table
   logic [63:0]   shadow_lo [SLOTS];
   logic [55:0]   shadow_hi [SLOTS];
   logic [3:0]    shadow_len [SLOTS];
   int            shadow_count;
   table_rsp_type pending_rsps [$];
   int            errors = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            hold_cycles = 0;
   longint        cycle_count = 0;

   // recently inserted keys, reused to hit present/delete paths
   logic [63:0] known_lo [$];
   logic [55:0] known_hi [$];
   logic [3:0]  known_len [$];

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      errors++;
   endtask

   function automatic int key_home(input logic [63:0] lo, input logic [55:0] hi,
                                   input int len);
      int sum;
      logic [7:0] b;
      sum = 0;
      for (int i = 0; i < len; i++) begin
         b = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
         sum += b * (i + 1);
      end
      return (19 * sum) % SLOTS;
   endfunction

   function automatic int find_slot(input logic [63:0] lo, input logic [55:0] hi,
                                    input logic [3:0] len);
      for (int s = 0; s < SLOTS; s++)
         if (shadow_len[s] == len && shadow_lo[s] == lo && shadow_hi[s] == hi) return s;
      return -1;
   endfunction

   function automatic table_rsp_type predict_table(input logic [1:0] cmd,
         input logic [63:0] lo_in, input logic [55:0] hi_in, input logic [3:0] len,
         input logic [6:0] idx);
      table_rsp_type r;
      logic [63:0] lo;
      logic [55:0] hi;
      int f, home, p;
      r = '0;
      lo = lo_in;
      hi = hi_in;
      for (int i = 0; i < 8; i++) if (i >= len) lo[8*i +: 8] = '0;
      for (int i = 0; i < 7; i++) if (i + 8 >= len) hi[8*i +: 8] = '0;
      case (cmd)
         CMD_INSERT, CMD_DELETE: begin
            if (len == 0) r.status = ST_EMPTY;
            else if (cmd == CMD_INSERT) begin
               if (find_slot(lo, hi, len) >= 0) r.status = ST_PRESENT;
               else begin
                  home = key_home(lo, hi, int'(len));
                  r.status = ST_NO_FREE;
                  for (int j = 0; j < PROBES; j++) begin
                     p = (home + j*j + 23*j) % SLOTS;
                     if (shadow_len[p] == 0) begin
                        shadow_lo[p] = lo;
                        shadow_hi[p] = hi;
                        shadow_len[p] = len;
                        shadow_count++;
                        r.status = ST_INSERTED;
                        r.slot = 7'(p);
                        break;
                     end
                  end
               end
            end else begin
               f = find_slot(lo, hi, len);
               if (f < 0) r.status = ST_NOT_FND;
               else begin
                  shadow_lo[f] = '0;
                  shadow_hi[f] = '0;
                  shadow_len[f] = '0;
                  shadow_count--;
                  r.status = ST_DELETED;
                  r.slot = 7'(f);
               end
            end
         end
         CMD_READ: begin
            r.status = ST_READ;
            r.slot = idx;
            if (idx < SLOTS && shadow_len[idx] != 0) begin
               r.occ = 1'b1;
               r.klo = shadow_lo[idx];
               r.khi = shadow_hi[idx];
               r.klen = shadow_len[idx];
            end
         end
         default: begin
            for (int s = 0; s < SLOTS; s++) begin
               shadow_lo[s] = '0;
               shadow_hi[s] = '0;
               shadow_len[s] = '0;
            end
            shadow_count = 0;
            r.status = ST_CLEARED;
         end
      endcase
      r.count = shadow_count[6:0];
      return r;
   endfunction

   // valid stays up between back-to-back beats; dropped only while idling
   task automatic send_command(input logic [1:0] cmd, input logic [63:0] lo,
         input logic [55:0] hi, input logic [3:0] len, input logic [6:0] idx);
      table_rsp_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {5'b0, idx, len, hi, lo};
      do @(posedge clock); while (!req_tready);
      r = predict_table(cmd, lo, hi, len, idx);
      pending_rsps = {pending_rsps, r};
      if (r.status == ST_INSERTED && known_lo.size() < 64) begin
         known_lo = {known_lo, lo};
         known_hi = {known_hi, hi};
         known_len = {known_len, len};
      end
   endtask

   // receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      table_rsp_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{status: rsp_tuser, slot: rsp_tdata[6:0], count: rsp_tdata[13:7],
                 occ: rsp_tdata[14], klo: rsp_tdata[78:15], khi: rsp_tdata[134:79],
                 klen: rsp_tdata[138:135]};
         if (pending_rsps.size() == 0) report_mismatch("unexpected beat", '0, '0);
         else begin
            want = pending_rsps.pop_front();
            if (got.status != want.status)
               report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.slot != want.slot) report_mismatch("slot", 64'(got.slot), 64'(want.slot));
            if (got.count != want.count)
               report_mismatch("count", 64'(got.count), 64'(want.count));
            if (got.occ != want.occ) report_mismatch("occupied", 64'(got.occ), 64'(want.occ));
            if (got.klo != want.klo) report_mismatch("key_lo", got.klo, want.klo);
            if (got.khi != want.khi) report_mismatch("key_hi", 64'(got.khi), 64'(want.khi));
            if (got.klen != want.klen)
               report_mismatch("key_len", 64'(got.klen), 64'(want.klen));
            if (rsp_tdata[143:139] != '0) report_mismatch("pad", 64'(rsp_tdata[143:139]), '0);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [55:0] rand56();
      logic [63:0] v;
      v = rand64();
      return v[55:0];
   endfunction

   // keys from a small alphabet when key_space is nonzero, so repeats and collisions happen
   task automatic random_command(input int key_space);
      int pick, k;
      logic [63:0] lo;
      logic [55:0] hi;
      logic [3:0] len;
      pick = $urandom_range(99);
      len = 4'($urandom_range(15));
      if (key_space > 0) begin
         lo = '0;
         hi = '0;
         for (int i = 0; i < 8; i++) lo[8*i +: 8] = 8'(8'h40 + $urandom_range(key_space));
         for (int i = 0; i < 7; i++) hi[8*i +: 8] = 8'(8'h40 + $urandom_range(key_space));
         if ($urandom_range(7) == 0) begin
            lo = rand64();
            hi = rand56();
         end
         lo = lo | (($urandom_range(3) == 0) ? rand64() << 8*len : 64'd0);
         len = (len == 0 && $urandom_range(9) != 0) ? 4'(1 + $urandom_range(3)) : len;
      end else begin
         lo = rand64();
         hi = rand56();
      end
      if (pick < 25 && known_lo.size() > 0) begin
         k = $urandom_range(known_lo.size() - 1);
         send_command($urandom_range(1) ? CMD_DELETE : CMD_INSERT,
                      known_lo[k], known_hi[k], known_len[k], 7'd0);
         if ($urandom_range(1)) begin
            known_lo.delete(k);
            known_hi.delete(k);
            known_len.delete(k);
         end
      end else if (pick < 65) send_command(CMD_INSERT, lo, hi, len, 7'($urandom_range(127)));
      else if (pick < 78) send_command(CMD_DELETE, lo, hi, len, 7'($urandom_range(127)));
      else if (pick < 99) send_command(CMD_READ, lo, hi, len,
                                       7'($urandom_range(9) ? $urandom_range(100)
                                                            : $urandom_range(127)));
      else begin
         send_command(CMD_CLEAR, lo, hi, len, 7'($urandom_range(127)));
         known_lo.delete();
         known_hi.delete();
         known_len.delete();
      end
   endtask

   task automatic test_directed();
      logic [63:0] ones_lo;
      logic [55:0] ones_hi;
      ones_lo = '1;
      ones_hi = '1;
      send_command(CMD_INSERT, 64'h41, '0, 4'd1, 7'd0);
      send_command(CMD_INSERT, 64'hFF41, '0, 4'd1, 7'd0);      // bytes past length ignored
      send_command(CMD_INSERT, ones_lo, ones_hi, 4'd15, 7'd127);
      send_command(CMD_INSERT, ones_lo, ones_hi, 4'd15, 7'd0);  // already present
      send_command(CMD_INSERT, ones_lo, ones_hi, 4'd0, 7'd0);   // empty key
      send_command(CMD_DELETE, ones_lo, ones_hi, 4'd0, 7'd0);
      send_command(CMD_INSERT, 64'h4342_4140, '0, 4'd4, 7'd0);
      for (int s = 0; s < 4; s++) send_command(CMD_READ, '0, '0, '0, 7'(s * 33));
      send_command(CMD_READ, ones_lo, ones_hi, 4'd15, 7'd100);
      send_command(CMD_READ, '0, '0, '0, 7'd101);               // beyond table
      send_command(CMD_READ, '0, '0, '0, 7'd127);
      send_command(CMD_DELETE, 64'h41, '0, 4'd1, 7'd0);
      send_command(CMD_DELETE, 64'h41, '0, 4'd1, 7'd0);          // not found
      send_command(CMD_DELETE, ones_lo, ones_hi, 4'd15, 7'd0);
      send_command(CMD_INSERT, 64'h5A, ones_hi, 4'd8, 7'd0);
      send_command(CMD_INSERT, ones_lo, 56'h12, 4'd9, 7'd0);
      send_command(CMD_CLEAR, ones_lo, ones_hi, 4'd15, 7'd127);
      send_command(CMD_READ, '0, '0, '0, 7'd0);
   endtask

   // two-byte keys of equal weighted sum collide at one home slot; fill the probe chain
   task automatic test_probe_exhaustion();
      for (int n = 0; n < 22; n++)
         send_command(CMD_INSERT, 64'({8'(n + 1), 8'(200 - 2*n)}), '0, 4'd2, 7'd0);
      for (int n = 0; n < 160; n++) send_command(CMD_INSERT, rand64(), rand56(), 4'd15, 7'd0);
      for (int s = 0; s < SLOTS; s++) send_command(CMD_READ, '0, '0, '0, 7'(s));
      send_command(CMD_CLEAR, '0, '0, '0, '0);
   endtask

   task automatic test_random(input int items, input int spct, input int rpct);
      send_idle_pct = spct;
      recv_idle_pct = rpct;
      for (int n = 0; n < items; n++) random_command(n % 3 == 0 ? 0 : 3);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 2000;
      for (int n = 0; n < 30; n++) random_command(3);
   endtask

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         shadow_lo[s] = '0;
         shadow_hi[s] = '0;
         shadow_len[s] = '0;
      end
      shadow_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_probe_exhaustion();
      test_random(450, 18, 80);
      test_random(450, 80, 18);
      test_backpressure();
      test_random(450, 0, 0);
      req_tvalid <= 1'b0;
      recv_idle_pct = 0;
      while (pending_rsps.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0 && pending_rsps.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
